>>> design/scd_pkg.sv
// scd_pkg: shared constants, codes and types for the task slot scheduler
// used by scd_table, scd_ctrl, the top level and the checker
package scd_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  localparam logic [31:0] MAIN_TASK_ID = 32'd1234;
  localparam logic [31:0] FREE_TASK_ID = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_CREATE   = 2'd0;
  localparam logic [1:0] CMD_RELEASE  = 2'd1;
  localparam logic [1:0] CMD_SCHEDULE = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef logic [SLOT_W-1:0] slot_t;

  // requests from the sequencer to the slot table
  typedef struct packed {
    logic        set_valid;
    logic        clr_valid;
    slot_t       wr_addr;
    logic [31:0] wr_id;
    logic        rd_en;
    slot_t       rd_addr;
  } tbl_req_t;

endpackage

>>> design/task_slot_round_robin_scheduler.sv
// task_slot_round_robin_scheduler: top level of the round robin task slot scheduler
// depends on scd_pkg, scd_table and scd_ctrl
//
// Usage:
//   A command is transferred at a rising edge with start high and busy low:
//   cmd selects create, release or schedule; create_id and release_slot
//   carry its operands. Exactly one result follows per command, shown on
//   status, chosen_slot, chosen_task_id and switched for one cycle while
//   done is high. The receiver cannot stall, so results must be taken then.
//   Steps from transfer to done:
//     release or unknown command: done is registered at the transfer
//     create: tests slots from 1 up to the lowest free slot, or all when full
//     schedule: one slot tested per cycle by the shared pointer until a valid
//     slot or the current one, then a read through the registered read port
//   busy is high while a create or schedule command runs; a new command may be
//   transferred in the cycle that done is shown. One command is in flight.
//   After reset the table holds only the main task in slot 0, the current
//   slot is 1 and the block is ready in the next cycle; there is no clearing
//   pass, free slots read their id from the valid flags.
module task_slot_round_robin_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] create_id,
  input  logic [3:0]  release_slot,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  chosen_slot,
  output logic [31:0] chosen_task_id,
  output logic        switched
);

  scd_pkg::tbl_req_t              req;
  logic [scd_pkg::SLOT_COUNT-1:0] valid_vec;
  logic [31:0]                    rd_id;

  scd_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .create_id      (create_id),
    .release_slot   (release_slot),
    .done           (done),
    .status         (status),
    .chosen_slot    (chosen_slot),
    .chosen_task_id (chosen_task_id),
    .switched       (switched),
    .req            (req),
    .valid_vec      (valid_vec),
    .rd_id          (rd_id)
  );

  scd_table u_table (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .valid_vec (valid_vec),
    .rd_id     (rd_id)
  );

endmodule

>>> design/scd_table.sv
// scd_table: slot valid flags and task id memory with a registered read port
// depends on scd_pkg
module scd_table (
  input  logic                      clk,
  input  logic                      rst,
  input  scd_pkg::tbl_req_t         req,
  output logic [scd_pkg::SLOT_COUNT-1:0] valid_vec,
  output logic [31:0]               rd_id
);

  logic [31:0]    mem [scd_pkg::SLOT_COUNT];
  logic [31:0]    rd_data;
  scd_pkg::slot_t rd_addr_q;
  logic           rd_valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_vec    <= '0;
      valid_vec[0] <= 1'b1;
    end else begin
      if (req.set_valid) valid_vec[req.wr_addr] <= 1'b1;
      if (req.clr_valid) valid_vec[req.wr_addr] <= 1'b0;
    end
  end

  // only create writes the memory; free slots read back as all ones
  always_ff @(posedge clk) begin
    if (req.set_valid) mem[req.wr_addr] <= req.wr_id;
    if (req.rd_en) begin
      rd_data    <= mem[req.rd_addr];
      rd_addr_q  <= req.rd_addr;
      rd_valid_q <= valid_vec[req.rd_addr];
    end
  end

  // slot 0 holds the main task and is never written
  assign rd_id = (rd_addr_q == '0) ? scd_pkg::MAIN_TASK_ID :
                 rd_valid_q        ? rd_data : scd_pkg::FREE_TASK_ID;

endmodule

>>> design/scd_ctrl.sv
// scd_ctrl: command sequencer with one shared slot pointer that scans the table
// depends on scd_pkg; drives scd_table through a tbl_req_t
module scd_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     cmd,
  input  logic [31:0]                    create_id,
  input  logic [3:0]                     release_slot,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [3:0]                     chosen_slot,
  output logic [31:0]                    chosen_task_id,
  output logic                           switched,
  output scd_pkg::tbl_req_t              req,
  input  logic [scd_pkg::SLOT_COUNT-1:0] valid_vec,
  input  logic [31:0]                    rd_id
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CREATE = 2'd1;
  localparam logic [1:0] S_SCHED  = 2'd2;
  localparam logic [1:0] S_READ   = 2'd3;

  localparam scd_pkg::slot_t LAST = scd_pkg::slot_t'(scd_pkg::SLOT_COUNT - 1);
  localparam scd_pkg::slot_t ONE  = scd_pkg::slot_t'(1);

  logic [1:0]     state;
  scd_pkg::slot_t ptr;
  scd_pkg::slot_t start_slot;
  scd_pkg::slot_t cur;
  scd_pkg::slot_t found;
  logic [31:0]    id_q;

  logic           accept;
  logic           rel_ok;
  logic           ptr_valid;
  scd_pkg::slot_t ptr_inc;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign rel_ok    = (release_slot != 4'd0) && (32'(release_slot) < scd_pkg::SLOT_COUNT);
  assign ptr_valid = valid_vec[ptr];
  assign ptr_inc   = ptr + ONE;

  always_comb begin
    req           = '0;
    req.wr_id     = id_q;
    req.wr_addr   = ptr;
    req.rd_addr   = ptr;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd == scd_pkg::CMD_RELEASE && rel_ok) begin
          req.clr_valid = 1'b1;
          req.wr_addr   = scd_pkg::slot_t'(release_slot);
        end
      end
      S_CREATE: req.set_valid = !ptr_valid;
      S_SCHED: begin
        req.rd_en = (ptr == start_slot) || ptr_valid;
        if (ptr == start_slot) req.rd_addr = start_slot;
      end
      S_READ: req = '0;
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= ONE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            id_q           <= create_id;
            start_slot     <= cur;
            status         <= scd_pkg::ST_REFUSED;
            chosen_slot    <= 4'd0;
            chosen_task_id <= 32'd0;
            switched       <= 1'b0;
            unique case (cmd)
              scd_pkg::CMD_CREATE: begin
                ptr   <= ONE;
                state <= S_CREATE;
              end
              scd_pkg::CMD_RELEASE: begin
                done <= 1'b1;
                if (rel_ok) begin
                  status         <= scd_pkg::ST_OK;
                  chosen_slot    <= release_slot;
                  chosen_task_id <= scd_pkg::FREE_TASK_ID;
                end
              end
              scd_pkg::CMD_SCHEDULE: begin
                ptr   <= (cur >= LAST) ? ONE : cur + ONE;
                state <= S_SCHED;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_CREATE: begin
          priority if (!ptr_valid) begin
            status         <= scd_pkg::ST_OK;
            chosen_slot    <= 4'(ptr);
            chosen_task_id <= id_q;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else if (ptr == LAST) begin
            status <= scd_pkg::ST_FULL;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            ptr <= ptr_inc;
          end
        end
        S_SCHED: begin
          // walk round robin from the slot after the current one, skipping slot 0
          priority if (ptr == start_slot) begin
            found <= start_slot;
            state <= S_READ;
          end else if (ptr_valid) begin
            found <= ptr;
            state <= S_READ;
          end else if (ptr == LAST) begin
            if (start_slot == '0) begin
              status <= scd_pkg::ST_NONE;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              ptr <= ONE;
            end
          end else begin
            ptr <= ptr_inc;
          end
        end
        S_READ: begin
          status         <= scd_pkg::ST_OK;
          chosen_slot    <= 4'(found);
          chosen_task_id <= rd_id;
          switched       <= (found != start_slot);
          cur            <= found;
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/scd_checker.sv
// scd_checker: port level assertions for the task slot scheduler, bound to the top
// depends on scd_pkg
module scd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  cmd,
  input logic        done,
  input logic [1:0]  status,
  input logic [3:0]  chosen_slot,
  input logic [31:0] chosen_task_id,
  input logic        switched
);

  // release and unknown commands show done in the cycle after the transfer
  a_short_cmd: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd == scd_pkg::CMD_RELEASE || cmd == scd_pkg::CMD_UNKNOWN)
    |=> done && !busy)
    else $error("short command did not complete in one cycle");

  // create always starts a scan
  a_create_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == scd_pkg::CMD_CREATE |=> busy && !done)
    else $error("create did not start a scan");

  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    done && switched |-> status == scd_pkg::ST_OK)
    else $error("switched set on a failed command");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != scd_pkg::ST_OK |-> chosen_slot == 4'd0 && chosen_task_id == 32'd0)
    else $error("failed command carries a slot or task id");

  a_ok_slot: assert property (@(posedge clk) disable iff (rst)
    done && status == scd_pkg::ST_OK && chosen_slot == 4'd0 |-> !switched)
    else $error("switch reported onto the main task slot");

endmodule

bind task_slot_round_robin_scheduler scd_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .cmd            (cmd),
  .done           (done),
  .status         (status),
  .chosen_slot    (chosen_slot),
  .chosen_task_id (chosen_task_id),
  .switched       (switched)
);
